/* design/efg_pkg.sv */
// Shared constants for the event-flag group engine: port widths, the
// operation and result-kind codes, and parameter defaults.
// No dependencies.
package efg_pkg;

   // Fixed port widths.
   localparam int TASK_W      = 8;
   localparam int FLAG_PORT_W = 32;
   localparam int KIND_W      = 3;

   // A set beat reports at most this many woken waiters.
   localparam int MAX_RESULTS = 8;
   localparam int WOKE_W      = $clog2(MAX_RESULTS + 1);

   // Parameter defaults for the top level.
   localparam int DEF_MAX_WAITERS = 8;
   localparam int DEF_FLAG_WIDTH  = 32;

   // Operation codes on req_op.
   localparam logic OP_WAIT = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // Result kinds on rsp_kind.
   localparam logic [KIND_W-1:0] KIND_IMMEDIATE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WOKEN     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET_NONE  = 3'd4;

endpackage

/* design/event_flag_group_engine_unit.sv */
// Event-flag group engine: flag word plus an ordered queue of blocked waiters.
// A wait beat, or a set beat with a zero mask or an empty queue, never raises
// busy and gives its one result in the cycle after it is taken.
// A set beat with queued waiters holds busy while the queue RAM is walked one
// entry a cycle through the single match unit, then through a closing finish
// state. Synchronous reset empties the queue and clears the flag word.
module event_flag_group_engine_unit #(
   parameter int MAX_WAITERS = efg_pkg::DEF_MAX_WAITERS,
   parameter int FLAG_WIDTH  = efg_pkg::DEF_FLAG_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_op,
   input  logic [efg_pkg::TASK_W-1:0]     req_task_id,
   input  logic [efg_pkg::FLAG_PORT_W-1:0] req_flag_mask,
   input  logic                           req_wait_all,
   input  logic                           req_clear_on_exit,
   output logic                           rsp_strobe,
   output logic [efg_pkg::KIND_W-1:0]     rsp_kind,
   output logic [efg_pkg::TASK_W-1:0]     rsp_woken_task,
   output logic [efg_pkg::FLAG_PORT_W-1:0] rsp_matched_bits,
   output logic [efg_pkg::FLAG_PORT_W-1:0] rsp_flags_now,
   output logic                           rsp_last
);

   import efg_pkg::*;

   // Flag bits above the port width can never be set, so they are not stored.
   localparam int FW      = (FLAG_WIDTH < FLAG_PORT_W) ? FLAG_WIDTH : FLAG_PORT_W;
   localparam int AW      = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam int CW      = $clog2(MAX_WAITERS + 1);
   localparam int ENTRY_W = TASK_W + FW + 2;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [FW-1:0]     flags_ff, flags_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     keep_ff, keep_in;
   logic [WOKE_W-1:0] nwoke_ff, nwoke_in;

   logic              pend_valid_ff, pend_valid_in;
   logic [TASK_W-1:0] pend_task_ff, pend_task_in;
   logic [FW-1:0]     pend_matched_ff, pend_matched_in;
   logic [FW-1:0]     pend_flags_ff, pend_flags_in;

   logic              strobe_ff, strobe_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TASK_W-1:0] task_ff, task_in;
   logic [FW-1:0]     matched_ff, matched_in;
   logic [FW-1:0]     flagsnow_ff, flagsnow_in;
   logic              last_ff, last_in;

   logic [FW-1:0]      mask_cut;
   logic               accept;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   logic [TASK_W-1:0] ent_task;
   logic [FW-1:0]     ent_mask;
   logic              ent_all;
   logic              ent_clr;

   logic [FW-1:0] m_req;
   logic          m_all;
   logic          m_clr;
   logic          m_hit;
   logic [FW-1:0] m_matched;
   logic [FW-1:0] m_next;

   assign mask_cut = req_flag_mask[FW-1:0];
   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);

   // Unpack the queue entry read during the walk.
   assign ent_task = ram_rd_data[ENTRY_W-1 -: TASK_W];
   assign ent_mask = ram_rd_data[FW+1:2];
   assign ent_all  = ram_rd_data[1];
   assign ent_clr  = ram_rd_data[0];

   efg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WAITERS)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The match unit serves the incoming wait when idle and each queue entry
   // during the walk.
   always_comb begin
      if (state_ff == S_WALK) begin
         m_req = ent_mask;
         m_all = ent_all;
         m_clr = ent_clr;
      end else begin
         m_req = mask_cut;
         m_all = req_wait_all;
         m_clr = req_clear_on_exit;
      end
   end

   efg_match #(
      .WIDTH (FW)
   ) u_match (
      .word      (flags_ff),
      .req       (m_req),
      .need_all  (m_all),
      .clears    (m_clr),
      .hit       (m_hit),
      .matched   (m_matched),
      .word_next (m_next)
   );

   // Sequencer: wait handling, set walk over the queue and result staging.
   always_comb begin
      state_in        = state_ff;
      flags_in        = flags_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      keep_in         = keep_ff;
      nwoke_in        = nwoke_ff;
      pend_valid_in   = pend_valid_ff;
      pend_task_in    = pend_task_ff;
      pend_matched_in = pend_matched_ff;
      pend_flags_in   = pend_flags_ff;
      strobe_in       = 1'b0;
      kind_in         = kind_ff;
      task_in         = task_ff;
      matched_in      = matched_ff;
      flagsnow_in     = flagsnow_ff;
      last_in         = last_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = count_ff[AW-1:0];
      ram_wr_data     = {req_task_id, mask_cut, req_wait_all, req_clear_on_exit};
      ram_rd_addr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_WAIT)) begin
               strobe_in   = 1'b1;
               last_in     = 1'b1;
               task_in     = req_task_id;
               matched_in  = '0;
               flagsnow_in = flags_ff;
               if (mask_cut == '0) begin
                  kind_in = KIND_REJECTED;
               end else if (m_hit) begin
                  kind_in     = KIND_IMMEDIATE;
                  matched_in  = m_matched;
                  flagsnow_in = m_next;
                  flags_in    = m_next;
               end else if (count_ff == CW'(MAX_WAITERS)) begin
                  kind_in = KIND_REJECTED;
               end else begin
                  kind_in   = KIND_QUEUED;
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
            end else if (accept) begin
               flags_in = flags_ff | mask_cut;
               if ((mask_cut == '0) || (count_ff == '0)) begin
                  strobe_in   = 1'b1;
                  last_in     = 1'b1;
                  kind_in     = KIND_SET_NONE;
                  task_in     = '0;
                  matched_in  = '0;
                  flagsnow_in = flags_ff | mask_cut;
               end else begin
                  state_in      = S_WALK;
                  idx_in        = '0;
                  keep_in       = '0;
                  nwoke_in      = '0;
                  pend_valid_in = 1'b0;
               end
            end
         end

         S_WALK: begin
            ram_rd_addr = idx_ff + AW'(1);
            idx_in      = idx_ff + AW'(1);
            if (m_hit && (nwoke_ff < WOKE_W'(MAX_RESULTS))) begin
               // Woken: the previous woken result can now go out as not last.
               flags_in        = m_next;
               nwoke_in        = nwoke_ff + WOKE_W'(1);
               pend_valid_in   = 1'b1;
               pend_task_in    = ent_task;
               pend_matched_in = m_matched;
               pend_flags_in   = m_next;
               if (pend_valid_ff) begin
                  strobe_in   = 1'b1;
                  last_in     = 1'b0;
                  kind_in     = KIND_WOKEN;
                  task_in     = pend_task_ff;
                  matched_in  = pend_matched_ff;
                  flagsnow_in = pend_flags_ff;
               end
            end else begin
               // Still blocked, or over the wake limit: compact it towards the head.
               ram_wr_en   = 1'b1;
               ram_wr_addr = keep_ff[AW-1:0];
               ram_wr_data = ram_rd_data;
               keep_in     = keep_ff + CW'(1);
            end
            if (idx_ff == AW'(count_ff - CW'(1))) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            state_in      = S_IDLE;
            count_in      = keep_ff;
            pend_valid_in = 1'b0;
            strobe_in     = 1'b1;
            last_in       = 1'b1;
            if (pend_valid_ff) begin
               kind_in     = KIND_WOKEN;
               task_in     = pend_task_ff;
               matched_in  = pend_matched_ff;
               flagsnow_in = pend_flags_ff;
            end else begin
               kind_in     = KIND_SET_NONE;
               task_in     = '0;
               matched_in  = '0;
               flagsnow_in = flags_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         flags_ff      <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flags_ff      <= flags_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   // Walk counters and result payload.
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      keep_ff         <= keep_in;
      nwoke_ff        <= nwoke_in;
      pend_task_ff    <= pend_task_in;
      pend_matched_ff <= pend_matched_in;
      pend_flags_ff   <= pend_flags_in;
      kind_ff         <= kind_in;
      task_ff         <= task_in;
      matched_ff      <= matched_in;
      flagsnow_ff     <= flagsnow_in;
      last_ff         <= last_in;
   end

   // Result ports, flag fields zero-extended to the port width.
   always_comb begin
      rsp_strobe       = strobe_ff;
      rsp_kind         = kind_ff;
      rsp_woken_task   = task_ff;
      rsp_last         = last_ff;
      rsp_matched_bits = '0;
      rsp_flags_now    = '0;
      rsp_matched_bits[FW-1:0] = matched_ff;
      rsp_flags_now[FW-1:0]    = flagsnow_ff;
   end

endmodule

/* design/efg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the waiter queue of the event-flag group engine. No dependencies.
module efg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/efg_match.sv */
// Shared condition unit: tests a request mask against the flag word in
// all-or-any mode and works out the matched bits and the word after clearing.
// No dependencies.
module efg_match #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] word,
   input  logic [WIDTH-1:0] req,
   input  logic             need_all,
   input  logic             clears,
   output logic             hit,
   output logic [WIDTH-1:0] matched,
   output logic [WIDTH-1:0] word_next
);

   // An empty request is always satisfied.
   always_comb begin
      matched = word & req;
      if (req == '0) begin
         hit = 1'b1;
      end else if (need_all) begin
         hit = (matched == req);
      end else begin
         hit = (matched != '0);
      end
      word_next = clears ? (word & ~matched) : word;
   end

endmodule

/* design/efg_checker.sv */
// Port-level checks for the event-flag group engine, bound to the top level.
// Depends on efg_pkg and event_flag_group_engine_unit.
module efg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            req_op,
   input logic                            rsp_strobe,
   input logic [efg_pkg::KIND_W-1:0]      rsp_kind,
   input logic [efg_pkg::TASK_W-1:0]      rsp_woken_task,
   input logic [efg_pkg::FLAG_PORT_W-1:0] rsp_matched_bits,
   input logic                            rsp_last
);

   import efg_pkg::*;

   // A wait beat always answers with one final result in the next cycle.
   a_wait_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_WAIT)) |=> (rsp_strobe && rsp_last))
      else $error("wait beat without a final result in the next cycle");

   // Only woken waiters can be followed by further results of the same beat.
   a_not_last_woken: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_kind == KIND_WOKEN))
      else $error("non-final result that is not a woken waiter");

   // The end of a queue walk always closes with a final result.
   a_walk_closes: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_last))
      else $error("queue walk ended without a final result");

   // Queued, rejected and empty set results carry no matched bits.
   a_no_match_bits: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_kind == KIND_QUEUED) || (rsp_kind == KIND_REJECTED) ||
                      (rsp_kind == KIND_SET_NONE))) |-> (rsp_matched_bits == '0))
      else $error("matched bits on a result that matched nothing");

   // A set that wakes nobody names no task.
   a_set_none_task: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == KIND_SET_NONE)) |-> (rsp_woken_task == '0))
      else $error("task id on a set result with no wake");

endmodule

bind event_flag_group_engine_unit efg_checker u_efg_checker (.*);
